@@ hdl/float_window_pose_matcher_macros.svh @@
// assertion macros for the matcher rtl
`ifndef FLOAT_WINDOW_POSE_MATCHER_MACROS_SVH
`define FLOAT_WINDOW_POSE_MATCHER_MACROS_SVH
`ifndef SYNTH
`define FWPM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define FWPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FWPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FWPM_ASSERT(lbl, cond, msg)
`define FWPM_ASSERT_IMP(lbl, ante, cons, msg)
`define FWPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/fwpm_pkg.sv @@
package fwpm_pkg;

	localparam int unsigned MATCH_LIMIT_DEF = 5000;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned PADDR_W = 3;

	// register indexes (paddr[2])
	localparam logic REG_EXPECTED_X = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	localparam logic [31:0] TOL_RESET = 32'h41F0_0000; // 30.0
	localparam logic [31:0] F_NEG_100 = 32'hC2C8_0000;
	localparam logic [31:0] F_POS_100 = 32'h42C8_0000;
	localparam logic [31:0] F_NEG_1P1 = 32'hBF8C_CCCD;
	localparam logic [31:0] F_POS_1P1 = 32'h3F8C_CCCD;
	localparam logic [31:0] F_POS_0P9 = 32'h3F66_6666;
	localparam logic [31:0] F_POS_INF = 32'h7F80_0000;

	function automatic logic f_is_nan(input logic [31:0] a);
		return (&a[30:23]) & (|a[22:0]);
	endfunction

	// monotonic key for non-nan floats, both zeros map together
	function automatic logic [31:0] f_key(input logic [31:0] a);
		logic [31:0] z;
		z = (a[30:0] == 31'd0) ? 32'd0 : a;
		return z[31] ? ~z : {1'b1, z[30:0]};
	endfunction

	// a < b for non-nan operands
	function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
		return f_key(a) < f_key(b);
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

endpackage

@@ hdl/fwpm_xdev.sv @@
// |x - expected_x| <= tolerance, two stages: align/add then normalize/round/compare
module fwpm_xdev (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [31:0] px,
	input  logic [31:0] ex,
	input  logic [31:0] tol,
	output logic        xok_s3
);
	logic        px_inf, ex_inf, ex_nan, swap, sub;
	logic [31:0] big, sml;
	logic [7:0]  e_big, e_sml, dd;
	logic [23:0] m_big, m_sml;
	logic [26:0] a27, s27, b27;
	logic [27:0] sum;

	logic [27:0] sum_s2;
	logic [7:0]  ebig_s2;
	logic        pass_s2, inf_s2;

	always_comb begin
		px_inf = (&px[30:23]) & ~(|px[22:0]);
		ex_inf = (&ex[30:23]) & ~(|ex[22:0]);
		ex_nan = fwpm_pkg::f_is_nan(ex);
		sub = (px[31] == ex[31]);
		swap = px[30:0] < ex[30:0];
		big = swap ? ex : px;
		sml = swap ? px : ex;
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		m_big = {|big[30:23], big[22:0]};
		m_sml = {|sml[30:23], sml[22:0]};
		dd = e_big - e_sml;
		a27 = {m_big, 3'b000};
		s27 = {m_sml, 3'b000};
		if (dd >= 8'd27) begin
			b27 = {26'd0, |m_sml};
		end else begin
			b27 = (s27 >> dd) | {26'd0, |(s27 & ((27'd1 << dd) - 27'd1))};
		end
		sum = sub ? ({1'b0, a27} - {1'b0, b27}) : ({1'b0, a27} + {1'b0, b27});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum;
			ebig_s2 <= e_big;
			// nan difference passes, inf minus inf included
			pass_s2 <= ex_nan | (px_inf & ex_inf & sub);
			inf_s2 <= (px_inf | ex_inf) & ~(ex_nan | (px_inf & ex_inf & sub));
		end
	end

	logic [4:0]  lz, sh;
	logic [7:0]  emx;
	logic [26:0] nrm;
	logic [9:0]  e, ef;
	logic        up;
	logic [24:0] m25;
	logic [23:0] mf;
	logic [31:0] dabs;
	logic        xok;

	always_comb begin
		lz = fwpm_pkg::lzc27(sum_s2[26:0]);
		emx = ebig_s2 - 8'd1;
		sh = ({3'd0, lz} > emx) ? emx[4:0] : lz;
		if (sum_s2[27]) begin
			nrm = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			e = {2'd0, ebig_s2} + 10'd1;
		end else begin
			nrm = sum_s2[26:0] << sh;
			e = {2'd0, ebig_s2} - {5'd0, sh};
		end
		up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
		m25 = {1'b0, nrm[26:3]} + {24'd0, up};
		if (m25[24]) begin
			mf = m25[24:1];
			ef = e + 10'd1;
		end else begin
			mf = m25[23:0];
			ef = e;
		end
		if (!mf[23]) ef = 10'd0;
		if (inf_s2 || ef >= 10'd255) begin
			dabs = fwpm_pkg::F_POS_INF;
		end else begin
			dabs = {1'b0, ef[7:0], mf[22:0]};
		end
		xok = pass_s2 | fwpm_pkg::f_is_nan(tol) | ~fwpm_pkg::f_lt(tol, dabs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xok_s3 <= 1'b0;
		end else if (adv) begin
			xok_s3 <= xok;
		end
	end
endmodule

@@ hdl/fwpm_mag.sv @@
// sine^2 + cosine^2 in [0.9, 1.1]: multiply, round squares, add/round/compare
module fwpm_mag (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [31:0] sine,
	input  logic [31:0] cosine,
	output logic        mok_s4
);
	logic [47:0] ps_s2, pc_s2;
	logic [7:0]  es_s2, ec_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ps_s2 <= {1'b1, sine[22:0]} * {1'b1, sine[22:0]};
			pc_s2 <= {1'b1, cosine[22:0]} * {1'b1, cosine[22:0]};
			es_s2 <= sine[30:23];
			ec_s2 <= cosine[30:23];
		end
	end

	// square of a normal value, results below the normal range flush to zero
	function automatic logic [31:0] sq_round(input logic [7:0] ex, input logic [47:0] p);
		logic [22:0] m;
		logic        g, st, up;
		logic signed [10:0] eq;
		logic [23:0] mr;
		if (p[47]) begin
			m = p[46:24];
			g = p[23];
			st = |p[22:0];
			eq = $signed({2'b00, ex, 1'b0}) - 11'sd126;
		end else begin
			m = p[45:23];
			g = p[22];
			st = |p[21:0];
			eq = $signed({2'b00, ex, 1'b0}) - 11'sd127;
		end
		up = g & (st | m[0]);
		mr = {1'b0, m} + {23'd0, up};
		if (mr[23]) eq = eq + 11'sd1;
		if (ex == 8'd0 || eq <= 11'sd0) return 32'd0;
		if (eq >= 11'sd255) return fwpm_pkg::F_POS_INF;
		return {1'b0, eq[7:0], mr[22:0]};
	endfunction

	logic [31:0] ss_s3, cc_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s3 <= sq_round(es_s2, ps_s2);
			cc_s3 <= sq_round(ec_s2, pc_s2);
		end
	end

	logic [31:0] big, sml, mag;
	logic [7:0]  dd;
	logic [49:0] a50, b50;
	logic [50:0] s51;
	logic [22:0] m;
	logic        g, st, up;
	logic [8:0]  e;
	logic [23:0] mr;
	logic        mok;

	always_comb begin
		big = (ss_s3[30:0] < cc_s3[30:0]) ? cc_s3 : ss_s3;
		sml = (ss_s3[30:0] < cc_s3[30:0]) ? ss_s3 : cc_s3;
		dd = big[30:23] - sml[30:23];
		a50 = {1'b1, big[22:0], 26'd0};
		b50 = {1'b1, sml[22:0], 26'd0} >> dd;
		s51 = {1'b0, a50} + {1'b0, b50};
		if (s51[50]) begin
			m = s51[49:27];
			g = s51[26];
			st = |s51[25:0];
			e = {1'b0, big[30:23]} + 9'd1;
		end else begin
			m = s51[48:26];
			g = s51[25];
			st = |s51[24:0];
			e = {1'b0, big[30:23]};
		end
		up = g & (st | m[0]);
		mr = {1'b0, m} + {23'd0, up};
		if (mr[23]) e = e + 9'd1;
		// a small addend far below the lsb leaves the larger value
		if (sml[30:0] == 31'd0 || dd > 8'd26) begin
			mag = big;
		end else begin
			mag = {1'b0, e[7:0], mr[22:0]};
		end
		mok = ~fwpm_pkg::f_lt(mag, fwpm_pkg::F_POS_0P9) &
			~fwpm_pkg::f_lt(fwpm_pkg::F_POS_1P1, mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mok_s4 <= 1'b0;
		end else if (adv) begin
			mok_s4 <= mok;
		end
	end
endmodule

@@ hdl/float_window_pose_matcher.sv @@
// path: a match goes through window capture, payload stages and the output register
// throughput: one word per cycle; the whole pipeline advances together and halts only
// while a result waits on m_axis with tready low
// reset: arst_n clears window fill, match count, valid flags and both registers
// (expected x = +0.0, tolerance = 30.0)
`include "float_window_pose_matcher_macros.svh"
module float_window_pose_matcher #(
	parameter int unsigned MATCH_LIMIT = fwpm_pkg::MATCH_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // word_bits[31:0], word_addr[79:32]
	input  logic         s_axis_tuser,  // region_start
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// match_addr[47:0], pos_x_bits[79:48], pos_y_bits[111:80], sine_bits[143:112],
	// cosine_bits[175:144]
	output logic [175:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [fwpm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int unsigned CNT_W = $clog2(MATCH_LIMIT + 1);

	// ---------------- configuration registers ----------------
	logic [31:0] target_x_q, tolerance_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= 32'd0;
			tolerance_q <= fwpm_pkg::TOL_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				fwpm_pkg::REG_EXPECTED_X: target_x_q <= pwdata;
				fwpm_pkg::REG_TOLERANCE:  tolerance_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fwpm_pkg::REG_EXPECTED_X: prdata = target_x_q;
			fwpm_pkg::REG_TOLERANCE:  prdata = tolerance_q;
			default: prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline advance ----------------
	// every stage moves when the output register is free or being drained
	logic adv;
	assign adv = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = adv;

	logic in_acc;
	assign in_acc = s_axis_tvalid & s_axis_tready;

	logic [31:0] in_word;
	logic [47:0] in_addr;
	assign in_word = s_axis_tdata[31:0];
	assign in_addr = s_axis_tdata[79:32];

	// ---------------- sliding window ----------------
	logic [31:0] win_q [3];
	logic [1:0]  fill_q;
	logic [1:0]  fill_eff;

	// region start empties the window before the new word goes in
	assign fill_eff = s_axis_tuser ? 2'd0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (in_acc) begin
			fill_q <= (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= in_word;
		end
	end

	// ---------------- stage 1: window capture ----------------
	logic        v_s1;
	logic [31:0] x_s1, y_s1, sn_s1, cs_s1;
	logic [47:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc && (fill_eff == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= win_q[0];
			y_s1 <= win_q[1];
			sn_s1 <= win_q[2];
			cs_s1 <= in_word;
			addr_s1 <= in_addr - 48'd12;
		end
	end

	// nan and range screens, all plain compares
	logic rng_ok;
	always_comb begin
		rng_ok = ~fwpm_pkg::f_is_nan(x_s1) & ~fwpm_pkg::f_is_nan(y_s1) &
			~fwpm_pkg::f_is_nan(sn_s1) & ~fwpm_pkg::f_is_nan(cs_s1);
		rng_ok = rng_ok &
			~fwpm_pkg::f_lt(y_s1, fwpm_pkg::F_NEG_100) &
			~fwpm_pkg::f_lt(fwpm_pkg::F_POS_100, y_s1) &
			~fwpm_pkg::f_lt(sn_s1, fwpm_pkg::F_NEG_1P1) &
			~fwpm_pkg::f_lt(fwpm_pkg::F_POS_1P1, sn_s1) &
			~fwpm_pkg::f_lt(cs_s1, fwpm_pkg::F_NEG_1P1) &
			~fwpm_pkg::f_lt(fwpm_pkg::F_POS_1P1, cs_s1);
	end

	// ---------------- arithmetic units ----------------
	logic xok_s3, mok_s4;

	fwpm_xdev u_xdev (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.px     (x_s1),
		.ex     (target_x_q),
		.tol    (tolerance_q),
		.xok_s3 (xok_s3)
	);

	fwpm_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sine   (sn_s1),
		.cosine (cs_s1),
		.mok_s4 (mok_s4)
	);

	// ---------------- stages 2..4: payload and flags ----------------
	logic         v_s2, v_s3, v_s4;
	logic         rok_s2, rok_s3, ok_s4;
	logic [175:0] pl_s2, pl_s3, pl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rok_s2 <= 1'b0;
			rok_s3 <= 1'b0;
			ok_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rok_s2 <= rng_ok;
			rok_s3 <= rok_s2;
			ok_s4 <= rok_s3 & xok_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s2 <= {cs_s1, sn_s1, y_s1, x_s1, addr_s1};
			pl_s3 <= pl_s2;
			pl_s4 <= pl_s3;
		end
	end

	// ---------------- match count and output register ----------------
	logic [CNT_W-1:0] match_count_q;
	logic [CNT_W-1:0] count_inc;
	logic             hit;

	assign count_inc = match_count_q + CNT_W'(1);

	// count check sits at the last stage so windows are judged in order
	assign hit = v_s4 & ok_s4 & mok_s4 & (match_count_q < CNT_W'(MATCH_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= hit;
			if (hit) match_count_q <= count_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) m_axis_tdata <= pl_s4;
	end

	`FWPM_ASSERT(a_count_cap, match_count_q <= CNT_W'(MATCH_LIMIT), "match count above limit")
	`FWPM_ASSERT_NXT(a_count_step, adv && hit, match_count_q == $past(count_inc), "no count step")
	`FWPM_ASSERT_IMP(a_out_counted, m_axis_tvalid, match_count_q != '0, "result without count")
	`FWPM_ASSERT_NXT(a_win_full, in_acc && (fill_eff != 2'd3), !v_s1, "window before full")
endmodule
